// ===== design/sha512_hash_engine_core_defines.svh =====
// Assertion macros for the SHA-512 engine top level
`ifndef SHA512_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA512_HASH_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, held off during reset
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sha512_pkg.sv =====
// Types, constants and helper functions for the SHA-512 engine
package sha512_pkg;

  localparam int unsigned NumRounds = 80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND_DATA, ST_PAD, ST_ROUND_PAD, ST_ZERO_LEN, ST_LEN, ST_ROUND_LAST, ST_EMIT
  } sha_state_e;

  typedef struct packed {
    logic write_byte;
    logic round;
    logic pad;
    logic len;
    logic zero_len;
    logic emit_next;
  } sha_cmd_t;

  typedef struct packed {
    logic block_full;
    logic pad_long;
    logic rounds_done;
    logic last_index;
  } sha_status_t;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [6:0] LenLimit = 7'd112;

  function automatic logic [63:0] init_chain(input logic [2:0] idx);
    logic [63:0] v;
    case (idx)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      3'd7: v = 64'h5be0cd19137e2179;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [63:0] round_const(input logic [6:0] r);
    logic [63:0] k;
    case (r)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== design/sha512_ctrl.sv =====
// Sequencer for absorb, padding, compression and digest output
module sha512_ctrl
  import sha512_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_byte_valid_i,
  input  logic        in_eom_i,
  input  logic        out_stall_i,
  input  sha_status_t status_i,
  output sha_cmd_t    cmd_o,
  output logic        in_stall_o,
  output logic        out_valid_o
);

  sha_state_e state_q, state_d;
  logic       eom_q, eom_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eom_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      eom_q   <= eom_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    eom_d       = eom_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.write_byte = in_byte_valid_i;
          eom_d            = in_eom_i;
          if (in_byte_valid_i && status_i.block_full) begin
            state_d = ST_ROUND_DATA;
          end else if (in_eom_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND_DATA: begin
        cmd_o.round = 1'b1;
        if (status_i.rounds_done) begin
          state_d = eom_q ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd_o.pad = 1'b1;
        state_d   = status_i.pad_long ? ST_ROUND_PAD : ST_LEN;
      end
      ST_ROUND_PAD: begin
        cmd_o.round = 1'b1;
        if (status_i.rounds_done) begin
          state_d = ST_ZERO_LEN;
        end
      end
      ST_ZERO_LEN: begin
        cmd_o.zero_len = 1'b1;
        state_d        = ST_ROUND_LAST;
      end
      ST_LEN: begin
        cmd_o.len = 1'b1;
        state_d   = ST_ROUND_LAST;
      end
      ST_ROUND_LAST: begin
        cmd_o.round = 1'b1;
        if (status_i.rounds_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.emit_next = 1'b1;
          if (status_i.last_index) begin
            state_d = ST_IDLE;
            eom_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/sha512_dpath.sv =====
// Block buffer, message schedule, round unit, chaining words and byte count
module sha512_dpath
  import sha512_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha_cmd_t    cmd_i,
  input  logic [7:0]  data_byte_i,
  output sha_status_t status_o,
  output out_word_t   out_word_o
);

  logic [63:0] blk_q   [16];  // block buffer, doubles as rolling schedule
  logic [63:0] chain_q [8];
  logic [63:0] work_q  [8];
  logic [63:0] count_q;
  logic [6:0]  rnd_q;
  logic [2:0]  idx_q;

  logic [6:0]  pos;
  logic [63:0] bits;
  logic [63:0] src [8];
  logic [63:0] t1, t2, big_s1, big_s0, ch, maj, w_new, sig0, sig1;
  logic        fold;

  assign pos  = count_q[6:0];
  assign bits = {count_q[60:0], 3'b000};
  assign fold = (rnd_q == 7'(NumRounds));

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      src[j] = (rnd_q == '0) ? chain_q[j] : work_q[j];
    end
    big_s1 = rotr(src[4], 14) ^ rotr(src[4], 18) ^ rotr(src[4], 41);
    ch     = (src[4] & src[5]) ^ (~src[4] & src[6]);
    big_s0 = rotr(src[0], 28) ^ rotr(src[0], 34) ^ rotr(src[0], 39);
    maj    = (src[0] & src[1]) ^ (src[0] & src[2]) ^ (src[1] & src[2]);
    t1     = src[7] + big_s1 + ch + round_const(rnd_q) + blk_q[0];
    t2     = big_s0 + maj;
    sig1   = rotr(blk_q[14], 19) ^ rotr(blk_q[14], 61) ^ (blk_q[14] >> 6);
    sig0   = rotr(blk_q[1], 1) ^ rotr(blk_q[1], 8) ^ (blk_q[1] >> 7);
    w_new  = sig1 + blk_q[9] + sig0 + blk_q[0];
  end

  // Buffer and working variables carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_byte) begin
      blk_q[pos[6:3]][(3'd7 - pos[2:0]) * 8 +: 8] <= data_byte_i;
    end else if (cmd_i.pad) begin
      for (int i = 0; i < 16; i++) begin
        for (int b = 0; b < 8; b++) begin
          if (7'(i * 8 + b) == pos) begin
            blk_q[i][(7 - b) * 8 +: 8] <= PadByte;
          end else if (7'(i * 8 + b) > pos) begin
            blk_q[i][(7 - b) * 8 +: 8] <= '0;
          end
        end
      end
    end else if (cmd_i.zero_len) begin
      for (int i = 0; i < 15; i++) begin
        blk_q[i] <= '0;
      end
      blk_q[15] <= bits;
    end else if (cmd_i.len) begin
      blk_q[15] <= bits;
    end else if (cmd_i.round && !fold) begin
      for (int i = 0; i < 15; i++) begin
        blk_q[i] <= blk_q[i + 1];
      end
      blk_q[15] <= w_new;
      work_q[0] <= t1 + t2;
      work_q[1] <= src[0];
      work_q[2] <= src[1];
      work_q[3] <= src[2];
      work_q[4] <= src[3] + t1;
      work_q[5] <= src[4];
      work_q[6] <= src[5];
      work_q[7] <= src[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 8; j++) begin
        chain_q[j] <= init_chain(3'(j));
      end
      count_q <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.write_byte) begin
        count_q <= count_q + 64'd1;
      end
      if (cmd_i.round) begin
        if (fold) begin
          rnd_q <= '0;
          for (int j = 0; j < 8; j++) begin
            chain_q[j] <= chain_q[j] + work_q[j];
          end
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end
      if (cmd_i.emit_next) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          for (int j = 0; j < 8; j++) begin
            chain_q[j] <= init_chain(3'(j));
          end
          count_q <= '0;
        end
      end
    end
  end

  assign status_o.block_full  = (pos == 7'd127);
  assign status_o.pad_long    = (pos >= LenLimit);
  assign status_o.rounds_done = fold;
  assign status_o.last_index  = (idx_q == 3'd7);

  assign out_word_o.digest_word = chain_q[idx_q];
  assign out_word_o.word_index  = idx_q;
  assign out_word_o.last_word   = (idx_q == 3'd7);

endmodule

// ===== design/sha512_hash_engine_core.sv =====
// Streaming SHA-512 hasher: top level joining sequencer and datapath
// Input: byte words are absorbed while idle; a byte that fills the block starts 80 rounds and a fold.
// End of message: pad, length, compression; past byte 111 the padded block goes first, then a zero block.
// Digest: 8 output words, one per cycle while the sink does not stall.
// Throughput bound by the single shared round unit: one round per cycle.
// Reset: asynchronous, active low; chaining words to the initial hash, byte count to zero.
`include "sha512_hash_engine_core_defines.svh"
module sha512_hash_engine_core
  import sha512_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  sha_cmd_t    cmd;
  sha_status_t status;

  // Sequencer: decides when to absorb, pad, compress and emit
  sha512_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_byte_valid_i(in_word_i.byte_valid),
    .in_eom_i       (in_word_i.end_of_message),
    .out_stall_i    (out_stall_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o)
  );

  // Datapath: buffer doubles as the rolling schedule, one round per cycle
  sha512_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .data_byte_i(in_word_i.data_byte),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

  `SHA_ASSERT_IMP(a_no_input_while_emit, out_valid_o, in_stall_o, "input open during digest output")
  `SHA_ASSERT_NXT(a_eom_blocks_input, in_valid_i && !in_stall_o && in_word_i.end_of_message, in_stall_o, "input open right after end of message")
  `SHA_ASSERT_NXT(a_idle_after_last, out_valid_o && !out_stall_i && out_word_o.last_word, !in_stall_o && !out_valid_o, "not idle after last digest word")

endmodule

// ===== dv/sha512_hash_engine_core_tb.sv =====
// Testbench for the streaming SHA-512 engine: directed and random byte streams checked against a digest model
module sha512_hash_engine_core_tb
  import sha512_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;

  // Digest model and store of expected digest words
  class digest_scoreboard;
    logic [63:0] chain[8];
    logic [7:0]  block_buf[128];
    logic [63:0] msg_bytes;
    out_word_t   pending[$];
    int unsigned errors;

    function void restart();
      for (int i = 0; i < 8; i++) begin
        chain[i] = iv_word(i);
      end
      msg_bytes = '0;
    endfunction

    function logic [63:0] iv_word(int i);
      logic [63:0] iv[8];
      iv = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
             64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
             64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
      return iv[i];
    endfunction

    function logic [63:0] ror(logic [63:0] v, int n);
      return (v >> n) | (v << (64 - n));
    endfunction

    function void compress();
      logic [63:0] k[80];
      logic [63:0] w[80];
      logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
      k = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
      for (int j = 0; j < 16; j++) begin
        w[j] = {block_buf[8*j], block_buf[8*j+1], block_buf[8*j+2], block_buf[8*j+3],
                block_buf[8*j+4], block_buf[8*j+5], block_buf[8*j+6], block_buf[8*j+7]};
      end
      for (int j = 16; j < 80; j++) begin
        w[j] = (ror(w[j-2], 19) ^ ror(w[j-2], 61) ^ (w[j-2] >> 6)) + w[j-7]
             + (ror(w[j-15], 1) ^ ror(w[j-15], 8) ^ (w[j-15] >> 7)) + w[j-16];
      end
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int r = 0; r < 80; r++) begin
        t1 = h + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & f) ^ (~e & g)) + k[r] + w[r];
        t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Absorb one accepted input word; queue the digest on end of message
    function void note_input(in_word_t iw);
      int unsigned pos;
      logic [63:0] bits;
      if (iw.byte_valid) begin
        pos = msg_bytes[6:0];
        block_buf[pos] = iw.data_byte;
        msg_bytes++;
        if (pos == 127) compress();
      end
      if (iw.end_of_message) begin
        pos = msg_bytes[6:0];
        block_buf[pos] = PadByte;
        pos++;
        if (pos > 112) begin
          for (int j = pos; j < 128; j++) block_buf[j] = '0;
          compress();
          pos = 0;
        end
        for (int j = pos; j < 120; j++) block_buf[j] = '0;
        bits = msg_bytes << 3;
        for (int j = 0; j < 8; j++) block_buf[120 + j] = bits[63 - 8*j -: 8];
        compress();
        for (int j = 0; j < 8; j++) begin
          pending.push_back('{digest_word: chain[j], word_index: 3'(j), last_word: j == 7});
        end
        restart();
      end
    endfunction

    function void check_output(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected digest word %h", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.digest_word !== exp_w.digest_word) begin
        $error("digest_word: expected %h, got %h", exp_w.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== exp_w.word_index) begin
        $error("word_index: expected %0d, got %0d", exp_w.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== exp_w.last_word) begin
        $error("last_word: expected %0d, got %0d", exp_w.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b1;
  out_word_t out_word_o;

  digest_scoreboard digests = new();
  bit          long_hold = 1'b0;
  bit          sink_hold_done = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned sent_items = 0;

  sha512_hash_engine_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  initial begin
    forever #4ns clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Offer one word and hold it until taken; valid stays up for a following word
  task automatic send_word(logic [7:0] b, logic bv, logic eom);
    int unsigned gap;
    gap = gap_len();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{data_byte: b, byte_valid: bv, end_of_message: eom};
    do @(posedge clk_i); while (in_stall_o);
    digests.note_input(in_word_i);
    sent_items++;
  endtask

  // Message of n bytes with random content; now and then an idle word without a byte
  task automatic send_message(int unsigned n, bit last_has_byte);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == n - 1) && last_has_byte);
    end
    if (!last_has_byte || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (digests.pending.size() != 0) @(posedge clk_i);
  endtask

  // Sink: random stalls; one long hold-off while the source keeps pushing
  initial begin
    int unsigned s;
    @(posedge rst_ni);
    forever begin
      if (long_hold && !sink_hold_done) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        sink_hold_done = 1'b1;
      end else begin
        s = gap_len();
        out_stall_i <= (s != 0);
        repeat (s == 0 ? $urandom_range(8, 1) : s) @(posedge clk_i);
      end
    end
  end

  // Output monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) digests.check_output(out_word_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("sha512_hash_engine_core_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    digests.restart();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, idle words, byte extremes, pad boundaries
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'haa, 1'b0, 1'b0);
    send_word(8'h55, 1'b1, 1'b1);
    send_message(112, 1'b1);
    wait_drained();

    // Long sink hold-off while the source keeps offering
    long_hold = 1'b1;
    send_message(3, 1'b1);
    send_message(2, 1'b0);
    send_message(128, 1'b1);
    wait_drained();

    // Random messages, mostly short; now and then a pause until everything drains
    while (sent_items < 360) begin
      case ($urandom_range(9))
        0: n = $urandom_range(140, 100);
        1: n = 0;
        default: n = $urandom_range(20, 1);
      endcase
      send_message(n, $urandom_range(1));
      if ($urandom_range(3) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (digests.errors == 0 && digests.pending.size() == 0) begin
      $display("sha512_hash_engine_core_tb passed");
    end else begin
      $display("sha512_hash_engine_core_tb failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/sha512_pkg.sv
design/sha512_ctrl.sv
design/sha512_dpath.sv
design/sha512_hash_engine_core.sv
dv/sha512_hash_engine_core_tb.sv
